@@ rtl/core/otv_pkg.sv @@
// ----------------------------------------------------------------------------
// otv_pkg: shared types and constants of the optimistic transaction validator
// Action and slot status codes, default sizes and stream payload widths.
// ----------------------------------------------------------------------------
package otv_pkg;

	// default sizing
	localparam int SLOTS_DEF = 8;
	localparam int WORDS_DEF = 64;

	// field widths
	localparam int ACTION_W = 2;
	localparam int TX_W     = 3;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [ACTION_W-1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_COMMIT = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE      = 2'd0,
		ST_LIVE      = 2'd1,
		ST_COMMITTED = 2'd2,
		ST_ABORTED   = 2'd3
	} status_t;

endpackage

@@ rtl/core/optimistic_tx_validator.sv @@
// ----------------------------------------------------------------------------
// optimistic_tx_validator: forward optimistic concurrency controller
// Transaction slots read and buffer writes against a shared word memory;
// a try-commit aborts on a read/write overlap with another live slot.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel s_axis_*: tuser carries the action (begin, read, write,
//    try commit), tdata carries slot, word address and write data.
//  - Response channel m_axis_*: exactly one transfer per request, in order,
//    with the read word (zero unless a read) and the slot status afterwards.
//  - One request is worked on at a time. Begin and write go straight from
//    the request transfer to the done state; a read of an in-range word
//    passes S_RD first for the registered shared memory read. A try commit
//    that goes ahead scans the other slots one per cycle and then copies the
//    buffered words one per cycle through the write buffer's read port. A
//    commit that aborts ends after the scan.
//  - The response sits in an output register; the block accepts the next
//    request while it waits. If the receiver stalls, a finished request
//    holds in the done state until the output register frees up.
//  - Reset clears slot status, bitmaps and the valid bits of the shared
//    memory (unwritten words read as zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
module optimistic_tx_validator #(
	parameter int SLOTS = otv_pkg::SLOTS_DEF,
	parameter int WORDS = otv_pkg::WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [otv_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // tx[2:0], addr[8:3], wdata[40:9]
	input  logic [otv_pkg::ACTION_W-1:0]   s_axis_tuser,  // action[1:0]
	// response channel
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [otv_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // rdata[31:0], status[33:32]
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;  // word index width
	localparam int XW = SW + otv_pkg::TX_W;               // tx, widened for slicing
	localparam int BUF_DEPTH = SLOTS * (2 ** AW);         // write buffer, {slot, word}

	// controller states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,  // shared memory read in flight
		S_SCAN = 5'b00100,  // conflict scan, one slot per cycle
		S_COPY = 5'b01000,  // copy buffered words to shared memory
		S_DONE = 5'b10000   // response ready, waiting for output register
	} state_t;

	// request fields
	logic [otv_pkg::TX_W-1:0]   in_tx;
	logic [otv_pkg::ADDR_W-1:0] in_addr;
	logic [otv_pkg::DATA_W-1:0] in_wdata;
	otv_pkg::action_t           in_action;
	logic [XW-1:0]              in_tx_ext;
	logic [SW-1:0]              in_slot;
	logic [AW-1:0]              in_word;
	logic                       in_slot_ok;
	logic                       in_addr_ok;
	logic                       in_live;
	logic                       accept;

	// control registers
	state_t                     state_q;
	logic [SW-1:0]              slot_q;
	logic [SW-1:0]              scan_q;
	logic [AW-1:0]              cp_q;
	logic                       conflict_q;
	logic [WORDS-1:0]           wmask_q;

	// slot state, flops
	otv_pkg::status_t           slot_status_q [SLOTS];
	logic [WORDS-1:0]           rbits_q [SLOTS];
	logic [WORDS-1:0]           wbits_q [SLOTS];
	logic [WORDS-1:0]           sh_valid_q;

	// memories
	logic [otv_pkg::DATA_W-1:0] shared_mem [WORDS];
	logic [otv_pkg::DATA_W-1:0] wbuf_mem [BUF_DEPTH];
	logic [otv_pkg::DATA_W-1:0] sh_rd_s1;
	logic                       sh_vld_s1;
	logic [otv_pkg::DATA_W-1:0] wbuf_rd_s1;
	logic [AW-1:0]              cp_word_s1;
	logic                       cp_vld_s1;
	logic                       cp_bit_s1;
	logic                       wbuf_we;
	logic [SW+AW-1:0]           wbuf_wa;
	logic [SW+AW-1:0]           wbuf_ra;

	// pending response and output register
	logic [otv_pkg::DATA_W-1:0] res_rdata_q;
	otv_pkg::status_t           res_status_q;
	logic                       out_vld_q;
	logic [otv_pkg::DATA_W-1:0] out_rdata_q;
	otv_pkg::status_t           out_status_q;
	logic                       out_free;

	logic                       scan_hit;
	logic                       scan_last;
	logic                       cp_last;

	// ---------------------------------------------------------------- decode
	assign in_tx     = s_axis_tdata[2:0];
	assign in_addr   = s_axis_tdata[8:3];
	assign in_wdata  = s_axis_tdata[40:9];
	assign in_action = otv_pkg::action_t'(s_axis_tuser);

	assign in_tx_ext  = XW'(in_tx);
	assign in_slot    = in_tx_ext[SW-1:0];
	assign in_word    = in_addr[AW-1:0];
	assign in_slot_ok = 32'(in_tx) < SLOTS;
	assign in_addr_ok = 32'(in_addr) < WORDS;
	assign in_live    = in_slot_ok && (slot_status_q[in_slot] == otv_pkg::ST_LIVE);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// conflict: another live slot has read a word this slot wrote
	assign scan_hit  = (scan_q != slot_q) &&
	                   (slot_status_q[scan_q] == otv_pkg::ST_LIVE) &&
	                   ((wmask_q & rbits_q[scan_q]) != '0);
	assign scan_last = (scan_q == SW'(SLOTS - 1));
	assign cp_last   = (cp_q == AW'(WORDS - 1));

	assign out_free = !out_vld_q || m_axis_tready;

	// ------------------------------------------------------ write buffer RAM
	assign wbuf_we = accept && (in_action == otv_pkg::ACT_WRITE) && in_addr_ok && in_live;
	assign wbuf_wa = {in_slot, in_word};
	assign wbuf_ra = {slot_q, cp_q};

	always_ff @(posedge clk) begin
		if (wbuf_we) begin
			wbuf_mem[wbuf_wa] <= in_wdata;
		end
		wbuf_rd_s1 <= wbuf_mem[wbuf_ra];
	end

	// ------------------------------------------------------ shared word RAM
	// Written only by the commit copy stage; read on a request transfer.
	always_ff @(posedge clk) begin
		if (cp_vld_s1 && cp_bit_s1) begin
			shared_mem[cp_word_s1] <= wbuf_rd_s1;
		end
		if (accept) begin
			sh_rd_s1 <= shared_mem[in_word];
		end
	end

	// copy stage bookkeeping and shared-word valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_vld_s1  <= 1'b0;
			cp_bit_s1  <= 1'b0;
			cp_word_s1 <= '0;
			sh_valid_q <= '0;
			sh_vld_s1  <= 1'b0;
		end else begin
			cp_vld_s1  <= (state_q == S_COPY);
			cp_bit_s1  <= wmask_q[cp_q];
			cp_word_s1 <= cp_q;
			if (cp_vld_s1 && cp_bit_s1) begin
				sh_valid_q[cp_word_s1] <= 1'b1;
			end
			if (accept) begin
				sh_vld_s1 <= sh_valid_q[in_word];
			end
		end
	end

	// ------------------------------------------------------------ controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			scan_q       <= '0;
			cp_q         <= '0;
			conflict_q   <= 1'b0;
			wmask_q      <= '0;
			res_rdata_q  <= '0;
			res_status_q <= otv_pkg::ST_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				slot_status_q[i] <= otv_pkg::ST_IDLE;
				rbits_q[i]       <= '0;
				wbits_q[i]       <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q      <= in_slot;
						res_rdata_q <= '0;
						if (!in_slot_ok) begin
							res_status_q <= otv_pkg::ST_IDLE;
							state_q      <= S_DONE;
						end else begin
							case (in_action)
								otv_pkg::ACT_BEGIN: begin
									rbits_q[in_slot]       <= '0;
									wbits_q[in_slot]       <= '0;
									slot_status_q[in_slot] <= otv_pkg::ST_LIVE;
									res_status_q           <= otv_pkg::ST_LIVE;
									state_q                <= S_DONE;
								end
								otv_pkg::ACT_READ: begin
									res_status_q <= slot_status_q[in_slot];
									state_q      <= in_addr_ok ? S_RD : S_DONE;
									if (in_addr_ok && in_live) begin
										rbits_q[in_slot][in_word] <= 1'b1;
									end
								end
								otv_pkg::ACT_WRITE: begin
									res_status_q <= slot_status_q[in_slot];
									state_q      <= S_DONE;
									if (in_addr_ok && in_live) begin
										wbits_q[in_slot][in_word] <= 1'b1;
									end
								end
								otv_pkg::ACT_COMMIT: begin
									res_status_q <= slot_status_q[in_slot];
									if (in_live) begin
										wmask_q    <= wbits_q[in_slot];
										scan_q     <= '0;
										conflict_q <= 1'b0;
										state_q    <= S_SCAN;
									end else begin
										state_q <= S_DONE;
									end
								end
								default: begin
									res_status_q <= slot_status_q[in_slot];
									state_q      <= S_DONE;
								end
							endcase
						end
					end
				end
				S_RD: begin
					res_rdata_q <= sh_vld_s1 ? sh_rd_s1 : '0;
					state_q     <= S_DONE;
				end
				S_SCAN: begin
					scan_q <= scan_q + SW'(1);
					if (scan_last) begin
						if (conflict_q || scan_hit) begin
							slot_status_q[slot_q] <= otv_pkg::ST_ABORTED;
							res_status_q          <= otv_pkg::ST_ABORTED;
							state_q               <= S_DONE;
						end else begin
							cp_q    <= '0;
							state_q <= S_COPY;
						end
					end else if (scan_hit) begin
						conflict_q <= 1'b1;
					end
				end
				S_COPY: begin
					// last buffered word is written in the cycle after, while in S_DONE
					cp_q <= cp_q + AW'(1);
					if (cp_last) begin
						slot_status_q[slot_q] <= otv_pkg::ST_COMMITTED;
						res_status_q          <= otv_pkg::ST_COMMITTED;
						state_q               <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			out_rdata_q  <= '0;
			out_status_q <= otv_pkg::ST_IDLE;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_vld_q    <= 1'b1;
				out_rdata_q  <= res_rdata_q;
				out_status_q <= res_status_q;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, out_status_q, out_rdata_q};

	// ------------------------------------------------------------ assertions
	a_resp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
		else $error("response raised outside the done state");

	a_copy_only_in_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> $past(state_q == S_COPY))
		else $error("shared memory copy outside a commit");

	a_no_copy_on_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> !conflict_q)
		else $error("commit copy after a detected conflict");

	a_commit_leaves_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_COPY) && cp_last) |=> (state_q == S_DONE) &&
		(res_status_q == otv_pkg::ST_COMMITTED))
		else $error("commit did not finish as committed");

endmodule

@@ tb/optimistic_tx_validator_tb.sv @@
// ----------------------------------------------------------------------------
// optimistic_tx_validator_tb: self-checking bench for the optimistic validator
// Drives begin/read/write/try-commit requests over the request stream and
// checks every response transfer, in order, against a bench copy of the
// slots, bitmaps, write buffers and shared memory. A directed table comes
// first, then random transaction traffic under four idle/stall mixes.
// ----------------------------------------------------------------------------
module optimistic_tx_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = otv_pkg::SLOTS_DEF;
	localparam int WORDS       = otv_pkg::WORDS_DEF;
	localparam int DATA_W      = otv_pkg::DATA_W;
	localparam int TX_W        = otv_pkg::TX_W;
	localparam int ADDR_W      = otv_pkg::ADDR_W;
	localparam int STATUS_W    = otv_pkg::STATUS_W;
	localparam int IN_TDATA_W  = otv_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = otv_pkg::OUT_TDATA_W;
	localparam int RESET_CYC   = 11;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 400;
	localparam int DRAIN_CYC   = 2 * (SLOTS + WORDS);
	localparam int NUM_ROWS    = 25;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		otv_pkg::status_t  status;
	} response_t;

	typedef struct packed {
		otv_pkg::action_t  act;
		logic [TX_W-1:0]   tx;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		bit                known;  // response typed in below
		response_t         resp;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [IN_TDATA_W-1:0]           s_axis_tdata  = '0;  // tx[2:0], addr[8:3], wdata[40:9]
	logic [otv_pkg::ACTION_W-1:0]    s_axis_tuser  = '0;  // action[1:0]
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]          m_axis_tdata;        // rdata[31:0], status[33:32]

	optimistic_tx_validator #(
		.SLOTS(SLOTS),
		.WORDS(WORDS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bench copy of the controller state
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] mem_words [WORDS];
	logic [DATA_W-1:0] tx_buffer [SLOTS][WORDS];
	logic [WORDS-1:0]  tx_reads  [SLOTS];
	logic [WORDS-1:0]  tx_writes [SLOTS];
	otv_pkg::status_t  tx_state  [SLOTS];

	response_t pending_responses [$];

	int errors       = 0;
	int checked      = 0;
	int cycles       = 0;
	int snd_pct      = 0;  // sender idle chance per cycle, percent
	int rcv_pct      = 0;  // receiver stall chance per cycle, percent
	int act_count [4] = '{0, 0, 0, 0};
	int commits_ok   = 0;
	int commits_abrt = 0;

	// Directed table. Typed responses: state right after reset, the extremes
	// and the abort cases; rows with known = 0 are checked by the predictor.
	directed_row_t directed_rows [NUM_ROWS] = '{
		// nothing started yet: reads see cleared memory, others are ignored
		'{otv_pkg::ACT_READ,   3'd0, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_IDLE}},
		'{otv_pkg::ACT_READ,   3'd7, 6'd63, 32'h0, 1'b1, '{32'h0, otv_pkg::ST_IDLE}},
		'{otv_pkg::ACT_COMMIT, 3'd3, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_IDLE}},
		'{otv_pkg::ACT_WRITE,  3'd2, 6'd5,  32'h1234_5678, 1'b1,
			'{32'h0, otv_pkg::ST_IDLE}},
		// slot 0 writes both ends, slot 7 reads the top word -> slot 0 aborts
		'{otv_pkg::ACT_BEGIN,  3'd0, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_BEGIN,  3'd7, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_WRITE,  3'd0, 6'd0,  32'h7FFF_FFFF, 1'b1,
			'{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_WRITE,  3'd0, 6'd63, 32'h8000_0000, 1'b1,
			'{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_READ,   3'd7, 6'd63, 32'h0, 1'b1, '{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_COMMIT, 3'd0, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_ABORTED}},
		// read on an aborted slot: word comes back, no read bit
		'{otv_pkg::ACT_READ,   3'd0, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_ABORTED}},
		// restart from aborted, overwrite a buffered word, read own write set
		'{otv_pkg::ACT_BEGIN,  3'd0, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_LIVE}},
		'{otv_pkg::ACT_WRITE,  3'd0, 6'd0,  32'h7FFF_FFFF, 1'b0, '0},
		'{otv_pkg::ACT_WRITE,  3'd0, 6'd0,  32'hFFFF_FFFF, 1'b0, '0},
		'{otv_pkg::ACT_WRITE,  3'd0, 6'd63, 32'h8000_0000, 1'b0, '0},
		'{otv_pkg::ACT_READ,   3'd0, 6'd0,  32'h0, 1'b0, '0},
		// slot 7 has no writes; then slot 0 sees only its own read bit
		'{otv_pkg::ACT_COMMIT, 3'd7, 6'd0,  32'h0, 1'b1,
			'{32'h0, otv_pkg::ST_COMMITTED}},
		'{otv_pkg::ACT_COMMIT, 3'd0, 6'd0,  32'h0, 1'b0, '0},
		'{otv_pkg::ACT_READ,   3'd7, 6'd63, 32'h0, 1'b0, '0},
		'{otv_pkg::ACT_COMMIT, 3'd0, 6'd0,  32'h0, 1'b0, '0},
		// slot 1 reads word 10, slot 2 writes it -> slot 2 aborts
		'{otv_pkg::ACT_BEGIN,  3'd1, 6'd0,  32'h0, 1'b0, '0},
		'{otv_pkg::ACT_READ,   3'd1, 6'd10, 32'h0, 1'b0, '0},
		'{otv_pkg::ACT_BEGIN,  3'd2, 6'd0,  32'h0, 1'b0, '0},
		'{otv_pkg::ACT_WRITE,  3'd2, 6'd10, 32'h2AAA_AAAA, 1'b0, '0},
		'{otv_pkg::ACT_COMMIT, 3'd2, 6'd0,  32'h0, 1'b1, '{32'h0, otv_pkg::ST_ABORTED}}
	};

	// Applies one request to the bench state and returns its response.
	function automatic response_t apply_request(otv_pkg::action_t act,
			logic [TX_W-1:0] slot, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
		response_t resp;
		bit        live;
		bit        clash;
		bit        addr_ok;
		resp    = '{rdata: '0, status: otv_pkg::ST_IDLE};
		clash   = 1'b0;
		addr_ok = (32'(addr) < WORDS);
		if (32'(slot) >= SLOTS)
			return resp;
		live = (tx_state[slot] == otv_pkg::ST_LIVE);
		case (act)
			otv_pkg::ACT_BEGIN: begin
				tx_reads[slot]  = '0;
				tx_writes[slot] = '0;
				tx_state[slot]  = otv_pkg::ST_LIVE;
			end
			otv_pkg::ACT_READ: begin
				if (addr_ok) begin
					resp.rdata = mem_words[addr];
					if (live)
						tx_reads[slot][addr] = 1'b1;
				end
			end
			otv_pkg::ACT_WRITE: begin
				if (live && addr_ok) begin
					tx_buffer[slot][addr] = wdata;
					tx_writes[slot][addr] = 1'b1;
				end
			end
			default: begin
				if (live) begin
					// the slot's own reads never count against it
					for (int i = 0; i < SLOTS; i++)
						if (i != slot && tx_state[i] == otv_pkg::ST_LIVE &&
								(tx_writes[slot] & tx_reads[i]) != '0)
							clash = 1'b1;
					if (clash) begin
						tx_state[slot] = otv_pkg::ST_ABORTED;
					end else begin
						for (int w = 0; w < WORDS; w++)
							if (tx_writes[slot][w])
								mem_words[w] = tx_buffer[slot][w];
						tx_state[slot] = otv_pkg::ST_COMMITTED;
					end
				end
			end
		endcase
		resp.status = tx_state[slot];
		return resp;
	endfunction

	// One request transfer; the response is predicted when it is accepted.
	task automatic send_request(otv_pkg::action_t act, logic [TX_W-1:0] tx,
			logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata, bit known,
			response_t typed);
		int        gap;
		bit        was_live;
		response_t resp;
		gap = 0;
		while ($urandom_range(99) < snd_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - TX_W - ADDR_W - DATA_W){1'b0}}, wdata, addr, tx};
		s_axis_tuser  <= act;
		do
			@(posedge clk);
		while (!s_axis_tready);
		was_live = (tx_state[tx] == otv_pkg::ST_LIVE);
		resp     = apply_request(act, tx, addr, wdata);
		if (known)
			resp = typed;
		pending_responses.push_back(resp);
		act_count[act]++;
		if (act == otv_pkg::ACT_COMMIT && was_live) begin
			if (resp.status == otv_pkg::ST_COMMITTED)
				commits_ok++;
			else
				commits_abrt++;
		end
	endtask

	// Random traffic: mostly well-formed transactions on a small set of hot
	// words so that overlaps and aborts are common, plus some plain noise.
	task automatic send_random(int count);
		otv_pkg::action_t  act;
		logic [TX_W-1:0]   tx;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		int                pick;
		for (int n = 0; n < count; n++) begin
			tx    = TX_W'($urandom_range(SLOTS - 1));
			addr  = ($urandom_range(99) < 70) ? ADDR_W'($urandom_range(7)) :
				ADDR_W'($urandom_range(WORDS - 1));
			wdata = $urandom;
			if ($urandom_range(99) < 15) begin
				act = otv_pkg::action_t'($urandom_range(3));
			end else if (tx_state[tx] != otv_pkg::ST_LIVE) begin
				act = otv_pkg::ACT_BEGIN;
			end else begin
				pick = $urandom_range(99);
				act  = (pick < 35) ? otv_pkg::ACT_READ :
					(pick < 75) ? otv_pkg::ACT_WRITE : otv_pkg::ACT_COMMIT;
			end
			send_request(act, tx, addr, wdata, 1'b0, '0);
		end
	endtask

	// Waits for every predicted response to come back.
	task automatic wait_drained();
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side: check each transfer, then pick the next ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin : response_check
		response_t want;
		response_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{rdata: m_axis_tdata[DATA_W-1:0],
				status: otv_pkg::status_t'(m_axis_tdata[DATA_W +: STATUS_W])};
			if (pending_responses.size() == 0) begin
				$error("response with none expected: rdata %h status %0d",
					got.rdata, got.status);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				checked++;
				if (got.rdata !== want.rdata) begin
					$error("rdata mismatch: expected %h, got %h", want.rdata, got.rdata);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d",
						want.status, got.status);
					errors++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= rcv_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, pending_responses.size());
			$display("optimistic_tx_validator test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		for (int w = 0; w < WORDS; w++)
			mem_words[w] = '0;
		for (int s = 0; s < SLOTS; s++) begin
			tx_reads[s]  = '0;
			tx_writes[s] = '0;
			tx_state[s]  = otv_pkg::ST_IDLE;
		end

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i])
			send_request(directed_rows[i].act, directed_rows[i].tx, directed_rows[i].addr,
				directed_rows[i].wdata, directed_rows[i].known, directed_rows[i].resp);

		// random phases; the sender holds off between phases until all
		// responses are back
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 50; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 50; end
				default: begin snd_pct = 37; rcv_pct = 37; end
			endcase
			send_random(PHASE_ITEMS);
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end
		snd_pct = 0;
		rcv_pct = 0;

		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d begin, %0d read, %0d write, %0d try-commit requests",
			act_count[otv_pkg::ACT_BEGIN], act_count[otv_pkg::ACT_READ],
			act_count[otv_pkg::ACT_WRITE], act_count[otv_pkg::ACT_COMMIT]);
		$display("%0d live commits went ahead, %0d aborted; %0d responses checked",
			commits_ok, commits_abrt, checked);
		if (errors == 0 && pending_responses.size() == 0) begin
			$display("optimistic_tx_validator test passed");
		end else begin
			$display("optimistic_tx_validator test failed");
		end
		$finish;
	end

endmodule
